// ----- hdl/tilt_complementary_filter_core_assert.svh -----
// assertion macros for the tilt complementary filter core
// used inside modules that have clk and rst_n in scope
`ifndef TILT_COMPLEMENTARY_FILTER_CORE_ASSERT_SVH
`define TILT_COMPLEMENTARY_FILTER_CORE_ASSERT_SVH

// same-cycle implication
`define TCF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcf assertion failed");

// next-cycle implication
`define TCF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcf assertion failed");

`endif

// ----- hdl/tcf_pkg.sv -----
// shared types, constants and the tilt lookup for the tilt complementary filter
// no dependencies
package tcf_pkg;

    localparam int NumLanes    = 2;
    localparam int ACCEL_W     = 10;
    localparam int GYRO_W      = 16;
    localparam int TICK_W      = 16;
    localparam int ANGLE_W     = 16;
    localparam int ACC_ANG_W   = 9;
    localparam int WEIGHT_W    = 8;
    localparam int TABLE_W     = 7;
    localparam int INDEX_W     = 6;
    localparam int PROD_W      = 32;
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 35;
    localparam int QUOT_W      = 17;
    localparam int SUM_W       = 19;
    localparam int KEEP_W      = 28;
    localparam int BLEND_W     = 29;
    localparam int BLEND_SHIFT = 7;

    localparam logic [WEIGHT_W-1:0] FULL_WEIGHT    = 8'd128;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET   = 8'd3;
    localparam logic [14:0]         TICK_DIVISOR   = 15'd20000;
    // floor(2^35 / 20000), quotient estimate is exact or one low
    localparam logic [RECIP_W-1:0]  TICK_RECIP     = 21'd1717986;
    localparam logic signed [ACC_ANG_W-1:0] HALF_TURN = 9'sd180;
    localparam logic [ACCEL_W-2:0]  MAX_INDEX      = 9'd63;

    localparam logic [TABLE_W-1:0] TILT_TABLE [64] = '{
        7'd0,  7'd1,  7'd2,  7'd3,  7'd4,  7'd5,  7'd5,  7'd6,
        7'd7,  7'd8,  7'd9,  7'd10, 7'd11, 7'd12, 7'd13, 7'd14,
        7'd15, 7'd16, 7'd17, 7'd18, 7'd19, 7'd19, 7'd20, 7'd21,
        7'd22, 7'd23, 7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29,
        7'd31, 7'd32, 7'd33, 7'd34, 7'd35, 7'd36, 7'd37, 7'd38,
        7'd39, 7'd41, 7'd42, 7'd43, 7'd44, 7'd46, 7'd47, 7'd48,
        7'd50, 7'd51, 7'd53, 7'd54, 7'd56, 7'd57, 7'd59, 7'd61,
        7'd63, 7'd65, 7'd67, 7'd69, 7'd72, 7'd76, 7'd80, 7'd90
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RECIP,
        ST_CORR,
        ST_SUM,
        ST_BLEND,
        ST_EMIT
    } tcf_state_t;

    typedef struct packed {
        logic capture;
        logic mul;
        logic recip;
        logic corr;
        logic sum;
        logic blend;
        logic emit;
    } tcf_cmd_t;

    // accelerometer tilt: table at |a|>>1 (saturated), signed, folded when z < 0
    function automatic logic signed [ACC_ANG_W-1:0] acc_tilt(
        input logic signed [ACCEL_W-1:0] a,
        input logic                      z_neg
    );
        logic [ACCEL_W-1:0]          mag;
        logic [ACCEL_W-2:0]          idx;
        logic [INDEX_W-1:0]          sat;
        logic signed [ACC_ANG_W-1:0] ang;
        logic signed [ACC_ANG_W-1:0] res;
        mag = a[ACCEL_W-1] ? ACCEL_W'(-a) : ACCEL_W'(a);
        idx = mag[ACCEL_W-1:1];
        sat = (idx > MAX_INDEX) ? INDEX_W'(MAX_INDEX) : idx[INDEX_W-1:0];
        ang = signed'(ACC_ANG_W'(TILT_TABLE[sat]));
        if (a[ACCEL_W-1])
        begin
            ang = -ang;
        end
        res = ang;
        if (z_neg)
        begin
            res = ang[ACC_ANG_W-1] ? (-HALF_TURN - ang) : (HALF_TURN - ang);
        end
        return res;
    endfunction

endpackage

// ----- hdl/tcf_controller.sv -----
// sequencer for the tilt complementary filter: handshakes and step commands
// depends on tcf_pkg and tilt_complementary_filter_core_assert.svh
`include "tilt_complementary_filter_core_assert.svh"

module tcf_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output tcf_pkg::tcf_cmd_t cmd
);
    import tcf_pkg::*;

    tcf_state_t state_reg;
    tcf_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       emit_ok;

    // output slot free or being drained this cycle
    assign emit_ok = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_MUL;
            ST_MUL:   state_next = ST_RECIP;
            ST_RECIP: state_next = ST_CORR;
            ST_CORR:  state_next = ST_SUM;
            ST_SUM:   state_next = ST_BLEND;
            ST_BLEND: state_next = ST_EMIT;
            ST_EMIT:  if (emit_ok) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_MUL:   cmd.mul   = 1'b1;
            ST_RECIP: cmd.recip = 1'b1;
            ST_CORR:  cmd.corr  = 1'b1;
            ST_SUM:   cmd.sum   = 1'b1;
            ST_BLEND: cmd.blend = 1'b1;
            ST_EMIT:  cmd.emit  = emit_ok;
            default:  cmd       = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    `TCF_ASSERT_NXT(a_accept_starts_work, in_valid && !in_stall, state_reg == ST_MUL)
    `TCF_ASSERT_NXT(a_emit_sets_valid, cmd.emit, out_valid_reg)
    `TCF_ASSERT_IMP(a_no_overwrite, cmd.emit, !(out_valid_reg && out_stall))
    `TCF_ASSERT_NXT(a_result_held, out_valid_reg && out_stall, out_valid_reg)

endmodule

// ----- hdl/tcf_datapath.sv -----
// arithmetic lanes for the x and y axes, blend weight and output registers
// depends on tcf_pkg
module tcf_datapath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  tcf_pkg::tcf_cmd_t                       cmd,
    input  logic                                    cfg_write_en,
    input  logic [tcf_pkg::WEIGHT_W-1:0]            cfg_write_data,
    input  logic signed [tcf_pkg::ACCEL_W-1:0]      accel_x,
    input  logic signed [tcf_pkg::ACCEL_W-1:0]      accel_y,
    input  logic signed [tcf_pkg::ACCEL_W-1:0]      accel_z,
    input  logic signed [tcf_pkg::GYRO_W-1:0]       gyro_x,
    input  logic signed [tcf_pkg::GYRO_W-1:0]       gyro_y,
    input  logic [tcf_pkg::TICK_W-1:0]              elapsed_ticks,
    output logic signed [tcf_pkg::ANGLE_W-1:0]      angle_x,
    output logic signed [tcf_pkg::ANGLE_W-1:0]      angle_y,
    output logic signed [tcf_pkg::ACC_ANG_W-1:0]    acc_angle_x,
    output logic signed [tcf_pkg::ACC_ANG_W-1:0]    acc_angle_y
);
    import tcf_pkg::*;

    localparam int RP_W = PROD_W + RECIP_W;

    logic [WEIGHT_W-1:0]          weight_reg;
    logic [WEIGHT_W-1:0]          weight_eff;
    logic [TICK_W-1:0]            dt_reg;

    logic signed [ACCEL_W-1:0]    accel_lane   [NumLanes];
    logic signed [GYRO_W-1:0]     gyro_lane    [NumLanes];

    logic signed [ACC_ANG_W-1:0]  acc_ang_reg  [NumLanes];
    logic [GYRO_W-1:0]            gmag_reg     [NumLanes];
    logic                         gneg_reg     [NumLanes];
    logic [PROD_W-1:0]            prod_reg     [NumLanes];
    logic [QUOT_W-1:0]            q0_reg       [NumLanes];
    logic [QUOT_W-1:0]            q_reg        [NumLanes];
    logic signed [SUM_W-1:0]      sum_reg      [NumLanes];
    logic signed [ANGLE_W-1:0]    filtered_reg [NumLanes];

    logic signed [ACC_ANG_W-1:0]  acc_ang_next [NumLanes];
    logic [GYRO_W-1:0]            gmag_next    [NumLanes];
    logic [PROD_W-1:0]            prod_next    [NumLanes];
    logic [QUOT_W-1:0]            q0_next      [NumLanes];
    logic [QUOT_W-1:0]            q_next       [NumLanes];
    logic signed [SUM_W-1:0]      sum_next     [NumLanes];
    logic signed [ANGLE_W-1:0]    filtered_next[NumLanes];

    assign accel_lane[0] = accel_x;
    assign accel_lane[1] = accel_y;
    assign gyro_lane[0]  = gyro_x;
    assign gyro_lane[1]  = gyro_y;

    // weights above full scale act as full scale
    assign weight_eff = (weight_reg > FULL_WEIGHT) ? FULL_WEIGHT : weight_reg;

    always_comb
    begin
        logic [RP_W-1:0]             recip_prod;
        logic [PROD_W-1:0]           back;
        logic [PROD_W-1:0]           rem;
        logic signed [SUM_W-1:0]     rate;
        logic signed [WEIGHT_W:0]    keep_w;
        logic signed [WEIGHT_W:0]    acc_w;
        logic signed [KEEP_W-1:0]    keep_term;
        logic signed [KEEP_W-1:0]    acc_term;
        logic signed [BLEND_W-1:0]   blend_sum;
        keep_w = signed'({1'b0, WEIGHT_W'(FULL_WEIGHT - weight_eff)});
        acc_w  = signed'({1'b0, weight_eff});
        for (int l = 0; l < NumLanes; l++)
        begin
            acc_ang_next[l] = acc_tilt(accel_lane[l], accel_z[ACCEL_W-1]);
            gmag_next[l]    = gyro_lane[l][GYRO_W-1] ? GYRO_W'(-gyro_lane[l])
                                                     : GYRO_W'(gyro_lane[l]);

            // |gyro| * dt
            prod_next[l] = PROD_W'(gmag_reg[l]) * PROD_W'(dt_reg);

            // quotient estimate by reciprocal multiply
            recip_prod = RP_W'(prod_reg[l]) * RP_W'(TICK_RECIP);
            q0_next[l] = recip_prod[RECIP_SHIFT +: QUOT_W];

            // estimate may be one low
            back      = PROD_W'(q0_reg[l]) * PROD_W'(TICK_DIVISOR);
            rem       = prod_reg[l] - back;
            q_next[l] = (rem >= PROD_W'(TICK_DIVISOR)) ? (q0_reg[l] + QUOT_W'(1))
                                                       : q0_reg[l];

            // truncated quotient takes the gyro sign
            rate = signed'(SUM_W'(q_reg[l]));
            if (gneg_reg[l])
            begin
                rate = -rate;
            end
            sum_next[l] = SUM_W'(filtered_reg[l]) + rate;

            keep_term        = keep_w * sum_reg[l];
            acc_term         = acc_w * acc_ang_reg[l];
            blend_sum        = BLEND_W'(keep_term) + BLEND_W'(acc_term);
            filtered_next[l] = blend_sum[BLEND_SHIFT +: ANGLE_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WEIGHT_RESET;
            for (int l = 0; l < NumLanes; l++)
            begin
                filtered_reg[l] <= '0;
            end
        end
        else
        begin
            if (cfg_write_en)
            begin
                weight_reg <= cfg_write_data;
            end
            if (cmd.blend)
            begin
                for (int l = 0; l < NumLanes; l++)
                begin
                    filtered_reg[l] <= filtered_next[l];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            dt_reg <= elapsed_ticks;
        end
        for (int l = 0; l < NumLanes; l++)
        begin
            if (cmd.capture)
            begin
                acc_ang_reg[l] <= acc_ang_next[l];
                gmag_reg[l]    <= gmag_next[l];
                gneg_reg[l]    <= gyro_lane[l][GYRO_W-1];
            end
            if (cmd.mul)
            begin
                prod_reg[l] <= prod_next[l];
            end
            if (cmd.recip)
            begin
                q0_reg[l] <= q0_next[l];
            end
            if (cmd.corr)
            begin
                q_reg[l] <= q_next[l];
            end
            if (cmd.sum)
            begin
                sum_reg[l] <= sum_next[l];
            end
        end
        if (cmd.emit)
        begin
            angle_x     <= filtered_reg[0];
            angle_y     <= filtered_reg[1];
            acc_angle_x <= acc_ang_reg[0];
            acc_angle_y <= acc_ang_reg[1];
        end
    end

endmodule

// ----- hdl/tilt_complementary_filter_core.sv -----
// top level of the tilt complementary filter: controller plus datapath
// depends on tcf_pkg, tcf_controller and tcf_datapath
//
//   channel  handshake                 words
//   in       in_valid / in_stall       accel_x, accel_y, accel_z, gyro_x, gyro_y,
//                                      elapsed_ticks
//   out      out_valid / out_stall     angle_x, angle_y, acc_angle_x, acc_angle_y
//   cfg      cfg_write_en              cfg_write_data (blend weight)
//
// each word passes the accept step, five arithmetic steps (gyro product,
// reciprocal multiply, quotient correction, gyro add, blend multiply) run on
// both axis lanes at once, then the output load, before the next word is taken
// reset clears both filtered angles and sets the blend weight to 3
// the output load waits while the previous result sits stalled; a new input
// word is taken while a finished result waits
module tilt_complementary_filter_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write_en,
    input  logic [tcf_pkg::WEIGHT_W-1:0]            cfg_write_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [tcf_pkg::ACCEL_W-1:0]      accel_x,
    input  logic signed [tcf_pkg::ACCEL_W-1:0]      accel_y,
    input  logic signed [tcf_pkg::ACCEL_W-1:0]      accel_z,
    input  logic signed [tcf_pkg::GYRO_W-1:0]       gyro_x,
    input  logic signed [tcf_pkg::GYRO_W-1:0]       gyro_y,
    input  logic [tcf_pkg::TICK_W-1:0]              elapsed_ticks,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [tcf_pkg::ANGLE_W-1:0]      angle_x,
    output logic signed [tcf_pkg::ANGLE_W-1:0]      angle_y,
    output logic signed [tcf_pkg::ACC_ANG_W-1:0]    acc_angle_x,
    output logic signed [tcf_pkg::ACC_ANG_W-1:0]    acc_angle_y
);
    import tcf_pkg::*;

    tcf_cmd_t cmd;

    tcf_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    tcf_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .accel_x        (accel_x),
        .accel_y        (accel_y),
        .accel_z        (accel_z),
        .gyro_x         (gyro_x),
        .gyro_y         (gyro_y),
        .elapsed_ticks  (elapsed_ticks),
        .angle_x        (angle_x),
        .angle_y        (angle_y),
        .acc_angle_x    (acc_angle_x),
        .acc_angle_y    (acc_angle_y)
    );

endmodule
